>>> sv/dq_pkg.sv
// Package for the double-ended queue: sizes, op and status codes, sequencer
// states and the ring-slot helper. No dependencies; imported by
// double_ended_queue_top.
package dq_pkg;

  // Storage geometry.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Field widths fixed by the item format.
  localparam int OP_W  = 3;
  localparam int IDX_W = 4;
  localparam int LEN_W = 5;
  localparam int ST_W  = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [DATA_W-1:0] data_t;

  // Request op codes.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_AT    = 3'd4,
    OP_RESIZE     = 3'd5,
    OP_ASSIGN     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_FILL = 4'b0100,
    S_FIN  = 4'b1000
  } fsm_t;

  // Where the data of a pending memory read goes.
  typedef enum logic [1:0] {
    TGT_FRONT = 2'd0,
    TGT_BACK  = 2'd1,
    TGT_READ  = 2'd2
  } tgt_t;

  // Ring slot that lies off positions after base, wrapped at DEPTH.
  function automatic ptr_t slot_add(ptr_t base, cnt_t off);
    sum_t sum;
    sum = sum_t'(base) + sum_t'(off);
    if (sum >= sum_t'(DEPTH)) begin
      sum = sum - sum_t'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> sv/double_ended_queue_top.sv
// Bounded double-ended queue kept as a ring buffer in one synchronous memory.
// Depends on dq_pkg for sizes, codes and the slot helper.
//
//  Channel | Ports                                            | Direction
//  --------+--------------------------------------------------+----------
//  request | in_valid/in_ready, in_op, in_value, in_index,    | in
//          | in_length                                        |
//  result  | out_valid/out_ready, out_status, out_read_value, | out
//          | out_front_value, out_back_value, out_occupancy,  |
//          | out_is_empty                                     |
//
// Pushes, clear, and every rejected or trivial request finish in the accept
// cycle. A pop that leaves entries, an in-range indexed read or a resize that
// shrinks to a non-zero length reads memory, captures the data in S_RD and
// loads the result in S_FIN. Growing resize and assign to a non-zero length
// write entries one at a time in S_FILL (one write port), then load in S_FIN.
// Reset clears head, count and the sequencer; memory contents stay undefined.
// A new item is taken only while the sequencer is idle and the result
// register is free or being emptied in the same cycle.
module double_ended_queue_top
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [DATA_W-1:0] in_value,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [LEN_W-1:0]  in_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic [DATA_W-1:0] out_read_value,
  output logic [DATA_W-1:0] out_front_value,
  output logic [DATA_W-1:0] out_back_value,
  output logic [CNT_W-1:0]  out_occupancy,
  output logic              out_is_empty
);

  // Entry storage.
  data_t mem [DEPTH];
  data_t mem_rdata_r;
  logic  mem_we, mem_re;
  ptr_t  mem_waddr, mem_raddr;
  data_t mem_wdata;

  // Control and shadow registers.
  fsm_t    state_r, state_nxt;
  ptr_t    head_r, head_nxt;
  cnt_t    count_r, count_nxt;
  data_t   front_r, front_nxt;
  data_t   back_r, back_nxt;
  status_t status_r, status_nxt;
  data_t   rdv_r, rdv_nxt;
  tgt_t    tgt_r, tgt_nxt;
  cnt_t    fill_tgt_r, fill_tgt_nxt;
  data_t   fill_val_r, fill_val_nxt;

  // Result register.
  logic    out_valid_r;
  status_t out_status_r;
  data_t   out_read_value_r, out_front_value_r, out_back_value_r;
  cnt_t    out_occupancy_r;
  logic    out_is_empty_r;

  logic acc, out_free, load_out, len_over;
  cnt_t len_sat;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;

  // Target length saturated at the depth.
  assign len_over = int'(in_length) > DEPTH;
  assign len_sat  = len_over ? cnt_t'(DEPTH) : cnt_t'(in_length);

  // Sequencer and request decode.
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    status_nxt   = status_r;
    rdv_nxt      = rdv_r;
    tgt_nxt      = tgt_r;
    fill_tgt_nxt = fill_tgt_r;
    fill_val_nxt = fill_val_r;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = slot_add(head_r, count_r);
    mem_raddr    = head_r;
    mem_wdata    = fill_val_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          status_nxt = ST_OK;
          rdv_nxt    = '0;
          unique case (op_t'(in_op))
            OP_PUSH_FRONT: begin
              load_out = 1'b1;
              if (count_r == cnt_t'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt  = slot_add(head_r, cnt_t'(DEPTH - 1));
                mem_we    = 1'b1;
                mem_waddr = head_nxt;
                mem_wdata = in_value;
                count_nxt = count_r + cnt_t'(1);
                front_nxt = in_value;
                if (count_r == '0) begin
                  back_nxt = in_value;
                end
              end
            end
            OP_PUSH_BACK: begin
              load_out = 1'b1;
              if (count_r == cnt_t'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_add(head_r, count_r);
                mem_wdata = in_value;
                count_nxt = count_r + cnt_t'(1);
                back_nxt  = in_value;
                if (count_r == '0) begin
                  front_nxt = in_value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                load_out   = 1'b1;
              end else begin
                head_nxt  = slot_add(head_r, cnt_t'(1));
                count_nxt = count_r - cnt_t'(1);
                if (count_r == cnt_t'(1)) begin
                  load_out = 1'b1;
                end else begin
                  // Fetch the new front entry.
                  mem_re    = 1'b1;
                  mem_raddr = slot_add(head_r, cnt_t'(1));
                  tgt_nxt   = TGT_FRONT;
                  state_nxt = S_RD;
                end
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                load_out   = 1'b1;
              end else begin
                count_nxt = count_r - cnt_t'(1);
                if (count_r == cnt_t'(1)) begin
                  load_out = 1'b1;
                end else begin
                  // Fetch the new back entry.
                  mem_re    = 1'b1;
                  mem_raddr = slot_add(head_r, count_r - cnt_t'(2));
                  tgt_nxt   = TGT_BACK;
                  state_nxt = S_RD;
                end
              end
            end
            OP_READ_AT: begin
              if (int'(in_index) >= int'(count_r)) begin
                status_nxt = ST_RANGE;
                load_out   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_add(head_r, cnt_t'(in_index));
                tgt_nxt   = TGT_READ;
                state_nxt = S_RD;
              end
            end
            OP_RESIZE: begin
              status_nxt = len_over ? ST_FULL : ST_OK;
              if (len_sat < count_r) begin
                // Shrinking trims the back; the new back is fetched.
                count_nxt = len_sat;
                if (len_sat == '0) begin
                  load_out = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = slot_add(head_r, len_sat - cnt_t'(1));
                  tgt_nxt   = TGT_BACK;
                  state_nxt = S_RD;
                end
              end else if (len_sat == count_r) begin
                load_out = 1'b1;
              end else begin
                fill_tgt_nxt = len_sat;
                fill_val_nxt = in_value;
                state_nxt    = S_FILL;
              end
            end
            OP_ASSIGN: begin
              status_nxt = len_over ? ST_FULL : ST_OK;
              head_nxt   = '0;
              count_nxt  = '0;
              if (len_sat == '0) begin
                load_out = 1'b1;
              end else begin
                fill_tgt_nxt = len_sat;
                fill_val_nxt = in_value;
                state_nxt    = S_FILL;
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
              load_out  = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        // Read data has arrived; route it to its shadow register.
        case (tgt_r)
          TGT_FRONT: front_nxt = mem_rdata_r;
          TGT_BACK:  back_nxt  = mem_rdata_r;
          TGT_READ:  rdv_nxt   = mem_rdata_r;
          default:   rdv_nxt   = mem_rdata_r;
        endcase
        state_nxt = S_FIN;
      end
      S_FILL: begin
        // Append one fill entry at the back each cycle.
        mem_we    = 1'b1;
        mem_waddr = slot_add(head_r, count_r);
        mem_wdata = fill_val_r;
        count_nxt = count_r + cnt_t'(1);
        back_nxt  = fill_val_r;
        if (count_r == '0) begin
          front_nxt = fill_val_r;
        end
        if (count_nxt == fill_tgt_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Shadow and working registers.
  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    status_r   <= status_nxt;
    rdv_r      <= rdv_nxt;
    tgt_r      <= tgt_nxt;
    fill_tgt_r <= fill_tgt_nxt;
    fill_val_r <= fill_val_nxt;
  end

  // Result register, loaded from the state after the operation.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r      <= status_nxt;
      out_read_value_r  <= rdv_nxt;
      out_front_value_r <= (count_nxt == '0) ? '0 : front_nxt;
      out_back_value_r  <= (count_nxt == '0) ? '0 : back_nxt;
      out_occupancy_r   <= count_nxt;
      out_is_empty_r    <= (count_nxt == '0);
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_front_value = out_front_value_r;
  assign out_back_value  = out_back_value_r;
  assign out_occupancy   = out_occupancy_r;
  assign out_is_empty    = out_is_empty_r;

`ifndef ASSERT_OFF
  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("entry count above depth");

  // The sequencer state stays one-hot.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  // A fill never runs past its target.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (count_r < fill_tgt_r))
    else $error("fill beyond target length");

  // A memory read is always followed by its capture cycle.
  a_read_capture: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (state_r == S_RD))
    else $error("memory read without capture");

  // The empty flag agrees with the occupancy of a shown result.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_is_empty_r == (out_occupancy_r == '0)))
    else $error("empty flag disagrees with occupancy");
`endif

endmodule
